>>> rtl/aabbq_pkg.sv
// ----------------------------------------------------------------------------
// aabbq_pkg
// Shared types, codes and defaults for the AABB collision group query block.
// ----------------------------------------------------------------------------
package aabbq_pkg;

    // default sizes, handed to the top level parameters
    localparam int DEF_MAX_OBJECTS   = 64;
    localparam int DEF_NUM_SHAPES    = 16;
    localparam int DEF_LIST_CAPACITY = 32;

    // field widths fixed by the item format
    localparam int OP_W    = 3;
    localparam int ID_W    = 6;
    localparam int BOX_W   = 4;
    localparam int GRP_W   = 3;
    localparam int POS_W   = 16;
    localparam int EXT_W   = 15;
    localparam int CNT_W   = 6;
    localparam int KIND_W  = 2;
    localparam int MASK_W  = 7;
    localparam int CFG_W   = 3;
    localparam int NUM_CFG = 8;

    // box bounds: corner + position + extent, exact
    localparam int XY_W = POS_W + 2;

    // groups with member lists
    localparam int NUM_GROUPS = 6;
    localparam logic [GRP_W-1:0] GRP_FIRST = 3'd1;
    localparam logic [GRP_W-1:0] GRP_LAST  = 3'd6;

    // operation codes
    localparam logic [OP_W-1:0] OP_WR_OBJ = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_BOX = 3'd1;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_HIT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVF  = 2'd2;

    typedef struct packed {
        logic [BOX_W-1:0]        box;
        logic [GRP_W-1:0]        grp;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } obj_rec_t;

    typedef struct packed {
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic [EXT_W-1:0]        w;
        logic [EXT_W-1:0]        h;
    } shape_rec_t;

    // member list update request
    typedef struct packed {
        logic             append;
        logic             clear;
        logic [GRP_W-1:0] grp;
        logic [ID_W-1:0]  oid;
    } mem_cmd_t;

endpackage

>>> rtl/aabb_collision_group_query_top.sv
// ----------------------------------------------------------------------------
// aabb_collision_group_query_top
// Broad-phase AABB overlap query over collision group member lists.
// ----------------------------------------------------------------------------
// Write items (object, box, append, clear) give no result.
// A query fetches the object, then its shape, and builds its box; it then
// walks groups 1 to 6 through a read pipeline (list RAM, object RAM,
// shape RAM, bounds add, compare) at one member per cycle while the output
// does not stall, with a step for every group, selected or not, and then
// drains the pipeline.
// Each hit is one result item; the last item is done or overflow. The whole
// pipeline stalls while the output register holds an item not yet taken.
// State lives in RAMs that need no clearing pass; group fill counts reset to
// zero. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module aabb_collision_group_query_top #(
    parameter int MAX_OBJECTS   = aabbq_pkg::DEF_MAX_OBJECTS,
    parameter int NUM_SHAPES    = aabbq_pkg::DEF_NUM_SHAPES,
    parameter int LIST_CAPACITY = aabbq_pkg::DEF_LIST_CAPACITY
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [aabbq_pkg::CFG_W-1:0]         cfg_index,
    input  logic [aabbq_pkg::MASK_W-1:0]        cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [aabbq_pkg::OP_W-1:0]          operation,
    input  logic [aabbq_pkg::ID_W-1:0]          object_id,
    input  logic [aabbq_pkg::BOX_W-1:0]         box_id,
    input  logic [aabbq_pkg::GRP_W-1:0]         group_id,
    input  logic signed [aabbq_pkg::POS_W-1:0]  pos_x,
    input  logic signed [aabbq_pkg::POS_W-1:0]  pos_y,
    input  logic [aabbq_pkg::EXT_W-1:0]         box_width,
    input  logic [aabbq_pkg::EXT_W-1:0]         box_height,
    input  logic [aabbq_pkg::CNT_W-1:0]         start_count,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [aabbq_pkg::KIND_W-1:0]        kind,
    output logic [aabbq_pkg::ID_W-1:0]          other_id,
    output logic                                last
);

    localparam int OBJ_AW  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int SHP_AW  = (NUM_SHAPES > 1) ? $clog2(NUM_SHAPES) : 1;
    localparam int LIST_AW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
    localparam int OBJ_XW  = OBJ_AW + aabbq_pkg::ID_W;
    localparam int SHP_XW  = SHP_AW + aabbq_pkg::BOX_W;
    localparam int OBJ_DW  = $bits(aabbq_pkg::obj_rec_t);
    localparam int SHP_DW  = $bits(aabbq_pkg::shape_rec_t);
    localparam int XY_W    = aabbq_pkg::XY_W;
    localparam int ID_W    = aabbq_pkg::ID_W;
    localparam int CNT_W   = aabbq_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_OBJ,
        ST_RD_SHP,
        ST_MK_BOX,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [aabbq_pkg::MASK_W-1:0] gmask_reg [aabbq_pkg::NUM_CFG];

    // query context
    logic [ID_W-1:0]                    q_oid_reg;
    logic signed [aabbq_pkg::POS_W-1:0] q_px_reg;
    logic signed [aabbq_pkg::POS_W-1:0] q_py_reg;
    logic [CNT_W-1:0]                   cnt_reg;
    logic [aabbq_pkg::MASK_W-1:0]       mask_reg;
    logic                               q_bok_reg;
    logic signed [XY_W-1:0]             ax1_reg, ay1_reg, ax2_reg, ay2_reg;

    // list walker
    logic [aabbq_pkg::GRP_W-1:0]        g_reg;
    logic [CNT_W-1:0]                   m_reg;
    logic                               exh_reg;

    // pipeline stages
    logic                               v1_reg, v2_reg, v3_reg, v4_reg;
    logic [ID_W-1:0]                    id2_reg, id3_reg, id4_reg;
    logic signed [aabbq_pkg::POS_W-1:0] x3_reg, y3_reg;
    logic                               bok3_reg;
    logic signed [XY_W-1:0]             bx1_reg, by1_reg, bx2_reg, by2_reg;

    // output register
    logic                               out_valid_reg;
    logic [aabbq_pkg::KIND_W-1:0]       kind_reg;
    logic [ID_W-1:0]                    other_reg;
    logic                               last_reg;

    logic                    in_acc;
    logic                    adv;
    logic                    scan;
    logic                    oid_ok;
    logic                    bid_ok;
    logic                    issue;
    logic                    hit4;
    logic                    cap_full;
    logic                    flush;
    logic                    pipe_busy;
    logic                    out_load;
    logic [CNT_W-1:0]        grp_count;
    logic [ID_W-1:0]         mem_id;
    logic                    mem_id_ok;
    aabbq_pkg::mem_cmd_t     mcmd;
    aabbq_pkg::obj_rec_t     obj_wr, obj_rd;
    aabbq_pkg::shape_rec_t   shp_wr, shp_rd, shp_use;
    logic [OBJ_XW-1:0]       obj_waddr_x, obj_raddr_x;
    logic [SHP_XW-1:0]       shp_waddr_x, shp_raddr_x;
    logic [OBJ_DW-1:0]       obj_rdata;
    logic [SHP_DW-1:0]       shp_rdata;
    logic                    obj_we, shp_we, ram_re;
    logic                    rd_bok;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign adv       = !out_valid_reg || out_ready;
    assign scan      = (state_reg == ST_SCAN);

    always_comb
    begin
        oid_ok    = int'(object_id) < MAX_OBJECTS;
        bid_ok    = int'(box_id) < NUM_SHAPES;
        obj_we    = in_acc && (operation == aabbq_pkg::OP_WR_OBJ) && oid_ok;
        shp_we    = in_acc && (operation == aabbq_pkg::OP_WR_BOX) && bid_ok;
        ram_re    = scan ? adv : 1'b1;

        obj_wr.box = box_id;
        obj_wr.grp = group_id;
        obj_wr.x   = pos_x;
        obj_wr.y   = pos_y;
        shp_wr.cx  = pos_x;
        shp_wr.cy  = pos_y;
        shp_wr.w   = box_width;
        shp_wr.h   = box_height;

        obj_rd  = aabbq_pkg::obj_rec_t'(obj_rdata);
        shp_rd  = aabbq_pkg::shape_rec_t'(shp_rdata);
        rd_bok  = int'(obj_rd.box) < NUM_SHAPES;

        obj_waddr_x = OBJ_XW'(object_id);
        obj_raddr_x = scan ? OBJ_XW'(mem_id) : OBJ_XW'(q_oid_reg);
        shp_waddr_x = SHP_XW'(box_id);
        shp_raddr_x = SHP_XW'(obj_rd.box);

        mcmd.append = in_acc && (operation == aabbq_pkg::OP_APPEND) && oid_ok;
        mcmd.clear  = in_acc && (operation == aabbq_pkg::OP_CLEAR);
        mcmd.grp    = group_id;
        mcmd.oid    = object_id;

        mem_id_ok = (mem_id != q_oid_reg) && (int'(mem_id) < MAX_OBJECTS);

        // shape slot past the table: zero corner, zero extent
        shp_use = (scan ? bok3_reg : q_bok_reg) ? shp_rd : '0;

        issue     = scan && !exh_reg && mask_reg[g_reg] && (m_reg < grp_count);
        pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;
        hit4      = v4_reg && (bx1_reg <= ax2_reg) && (ax1_reg <= bx2_reg)
                    && (by1_reg <= ay2_reg) && (ay1_reg <= by2_reg);
        cap_full  = int'(cnt_reg) >= LIST_CAPACITY;
        flush     = scan && adv && hit4 && cap_full;
        // a new result item goes into the output register this cycle
        out_load  = adv && ((scan && (hit4 || (exh_reg && !pipe_busy)))
                            || (state_reg == ST_DONE));
    end

    aabbq_ram #(
        .WIDTH (OBJ_DW),
        .DEPTH (MAX_OBJECTS)
    ) u_obj_ram (
        .clk   (clk),
        .we    (obj_we),
        .waddr (obj_waddr_x[OBJ_AW-1:0]),
        .wdata (obj_wr),
        .re    (ram_re),
        .raddr (obj_raddr_x[OBJ_AW-1:0]),
        .rdata (obj_rdata)
    );

    aabbq_ram #(
        .WIDTH (SHP_DW),
        .DEPTH (NUM_SHAPES)
    ) u_shape_ram (
        .clk   (clk),
        .we    (shp_we),
        .waddr (shp_waddr_x[SHP_AW-1:0]),
        .wdata (shp_wr),
        .re    (ram_re),
        .raddr (shp_raddr_x[SHP_AW-1:0]),
        .rdata (shp_rdata)
    );

    aabbq_members #(
        .LIST_CAPACITY (LIST_CAPACITY)
    ) u_members (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (mcmd),
        .rd_grp (g_reg),
        .rd_idx (m_reg[LIST_AW-1:0]),
        .rd_en  (adv),
        .rd_id  (mem_id),
        .count  (grp_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < aabbq_pkg::NUM_CFG; i++)
            begin
                gmask_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            gmask_reg[cfg_index] <= cfg_data;
        end
    end

    // control FSM and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            kind_reg      <= aabbq_pkg::KIND_DONE;
            other_reg     <= '0;
            last_reg      <= 1'b0;
            q_oid_reg     <= '0;
            q_px_reg      <= '0;
            q_py_reg      <= '0;
            cnt_reg       <= '0;
            mask_reg      <= '0;
            q_bok_reg     <= 1'b0;
            ax1_reg       <= '0;
            ay1_reg       <= '0;
            ax2_reg       <= '0;
            ay2_reg       <= '0;
            g_reg         <= aabbq_pkg::GRP_FIRST;
            m_reg         <= '0;
            exh_reg       <= 1'b1;
        end
        else
        begin
            if (out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && (operation == aabbq_pkg::OP_QUERY))
                    begin
                        q_oid_reg <= object_id;
                        q_px_reg  <= pos_x;
                        q_py_reg  <= pos_y;
                        cnt_reg   <= start_count;
                        state_reg <= oid_ok ? ST_RD_OBJ : ST_DONE;
                    end
                end
                ST_RD_OBJ:
                begin
                    state_reg <= ST_RD_SHP;
                end
                ST_RD_SHP:
                begin
                    mask_reg  <= gmask_reg[obj_rd.grp];
                    q_bok_reg <= rd_bok;
                    state_reg <= ST_MK_BOX;
                end
                ST_MK_BOX:
                begin
                    ax1_reg   <= XY_W'(shp_use.cx) + XY_W'(q_px_reg);
                    ay1_reg   <= XY_W'(shp_use.cy) + XY_W'(q_py_reg);
                    ax2_reg   <= XY_W'(shp_use.cx) + XY_W'(q_px_reg) + XY_W'(shp_use.w);
                    ay2_reg   <= XY_W'(shp_use.cy) + XY_W'(q_py_reg) + XY_W'(shp_use.h);
                    g_reg     <= aabbq_pkg::GRP_FIRST;
                    m_reg     <= '0;
                    exh_reg   <= 1'b0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    // walk groups in order, one member (unless stalled) or one group step a cycle
                    if (issue)
                    begin
                        if (adv)
                        begin
                            m_reg <= m_reg + CNT_W'(1);
                        end
                    end
                    else if (!exh_reg && !flush)
                    begin
                        if (g_reg == aabbq_pkg::GRP_LAST)
                        begin
                            exh_reg <= 1'b1;
                        end
                        else
                        begin
                            g_reg <= g_reg + aabbq_pkg::GRP_W'(1);
                            m_reg <= '0;
                        end
                    end

                    if (adv)
                    begin
                        if (hit4)
                        begin
                            out_valid_reg <= 1'b1;
                            if (cap_full)
                            begin
                                kind_reg  <= aabbq_pkg::KIND_OVF;
                                other_reg <= '0;
                                last_reg  <= 1'b1;
                                exh_reg   <= 1'b1;
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                kind_reg  <= aabbq_pkg::KIND_HIT;
                                other_reg <= id4_reg;
                                last_reg  <= 1'b0;
                                cnt_reg   <= cnt_reg + CNT_W'(1);
                            end
                        end
                        else if (exh_reg && !pipe_busy)
                        begin
                            out_valid_reg <= 1'b1;
                            kind_reg      <= aabbq_pkg::KIND_DONE;
                            other_reg     <= '0;
                            last_reg      <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (adv)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= aabbq_pkg::KIND_DONE;
                        other_reg     <= '0;
                        last_reg      <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // pipeline valids; every stage moves together on adv, all clear on flush
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (flush)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg && mem_id_ok;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            id2_reg  <= mem_id;
            id3_reg  <= id2_reg;
            x3_reg   <= obj_rd.x;
            y3_reg   <= obj_rd.y;
            bok3_reg <= rd_bok;
            id4_reg  <= id3_reg;
            bx1_reg  <= XY_W'(shp_use.cx) + XY_W'(x3_reg);
            by1_reg  <= XY_W'(shp_use.cy) + XY_W'(y3_reg);
            bx2_reg  <= XY_W'(shp_use.cx) + XY_W'(x3_reg) + XY_W'(shp_use.w);
            by2_reg  <= XY_W'(shp_use.cy) + XY_W'(y3_reg) + XY_W'(shp_use.h);
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign other_id  = other_reg;
    assign last      = last_reg;

    // new items only with an empty pipeline
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !pipe_busy)
        else $error("item accepted with members in flight");

    // a query always closes with a last result
    a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> (out_valid_reg && last_reg))
        else $error("query ended without a last result");

    // a pending hit item only exists mid-scan
    a_hit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> scan)
        else $error("hit result outside a scan");

    // a blocked compare stage keeps its member
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (scan && !adv && v4_reg) |=> (v4_reg && $stable(id4_reg)))
        else $error("compare stage lost its member on stall");

endmodule

>>> rtl/aabbq_ram.sv
// ----------------------------------------------------------------------------
// aabbq_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module aabbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/aabbq_members.sv
// ----------------------------------------------------------------------------
// aabbq_members
// Per-group member lists: list RAM plus fill counts, append and clear.
// ----------------------------------------------------------------------------
module aabbq_members #(
    parameter int LIST_CAPACITY = aabbq_pkg::DEF_LIST_CAPACITY,
    localparam int LIST_AW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  aabbq_pkg::mem_cmd_t         cmd,
    input  logic [aabbq_pkg::GRP_W-1:0] rd_grp,
    input  logic [LIST_AW-1:0]          rd_idx,
    input  logic                        rd_en,
    output logic [aabbq_pkg::ID_W-1:0]  rd_id,
    output logic [aabbq_pkg::CNT_W-1:0] count
);

    localparam int GW    = aabbq_pkg::GRP_W;
    localparam int DEPTH = aabbq_pkg::NUM_GROUPS << LIST_AW;

    logic [aabbq_pkg::CNT_W-1:0] count_reg [aabbq_pkg::NUM_GROUPS];

    logic [GW-1:0]          sel_grp;
    logic [GW-1:0]          sel_idx;
    logic                   grp_ok;
    logic                   has_room;
    logic                   wr_en;
    logic [GW+LIST_AW-1:0]  waddr;
    logic [GW+LIST_AW-1:0]  raddr;
    logic [GW-1:0]          rd_gidx;

    always_comb
    begin
        sel_grp  = (cmd.append || cmd.clear) ? cmd.grp : rd_grp;
        grp_ok   = sel_grp inside {[aabbq_pkg::GRP_FIRST:aabbq_pkg::GRP_LAST]};
        sel_idx  = sel_grp - GW'(1);
        count    = grp_ok ? count_reg[sel_idx] : '0;
        has_room = int'(count) < LIST_CAPACITY;
        wr_en    = cmd.append && grp_ok && has_room;
        waddr    = {sel_idx, count[LIST_AW-1:0]};
        rd_gidx  = rd_grp - GW'(1);
        raddr    = {rd_gidx, rd_idx};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < aabbq_pkg::NUM_GROUPS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (cmd.clear && grp_ok)
        begin
            count_reg[sel_idx] <= '0;
        end
        else if (wr_en)
        begin
            count_reg[sel_idx] <= count + aabbq_pkg::CNT_W'(1);
        end
    end

    aabbq_ram #(
        .WIDTH (aabbq_pkg::ID_W),
        .DEPTH (DEPTH)
    ) u_list_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (cmd.oid),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (rd_id)
    );

    // a list never holds more than its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count) <= LIST_CAPACITY)
        else $error("member count above capacity");

    // a clear empties the list by the next cycle
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clear && grp_ok) |=> count_reg[$past(sel_idx)] == '0)
        else $error("clear did not empty the list");

    // an append to a list with room grows it by one
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !cmd.clear) |=>
            count_reg[$past(sel_idx)] == $past(count) + aabbq_pkg::CNT_W'(1))
        else $error("append did not grow the list");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the AABB collision group query block. A scene of
// boxes, objects and group lists is built with write items, then queried;
// a local scene copy predicts every hit, done and overflow item, and each
// result is checked in order. Group masks change between phases; both sides
// throttle at random in the first two phases; the third adds one long output stall.
// ----------------------------------------------------------------------------
module tb;
    import aabbq_pkg::*;

    localparam int N_OBJ         = DEF_MAX_OBJECTS;
    localparam int N_SHAPE       = DEF_NUM_SHAPES;
    localparam int LIST_CAP      = DEF_LIST_CAPACITY;
    localparam int HOLD_CYCLES   = 800;
    localparam int SETTLE_CYCLES = 250;
    localparam logic [OP_W-1:0] OP_TOP_CODE = '1;
    localparam logic [MASK_W-1:0] FIRST_MASKS [NUM_CFG] =
        '{7'h7F, 7'h7E, 7'h06, 7'h48, 7'h00, 7'h01, 7'h7E, 7'h7E};

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [ID_W-1:0]         oid;
        logic [BOX_W-1:0]        bid;
        logic [GRP_W-1:0]        gid;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic [EXT_W-1:0]        bw;
        logic [EXT_W-1:0]        bh;
        logic [CNT_W-1:0]        start;
    } scene_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   other;
        logic              last;
    } report_t;

    typedef struct packed {
        logic [CFG_W-1:0]  index;
        logic [MASK_W-1:0] data;
    } mask_write_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_W-1:0]         cfg_index = '0;
    logic [MASK_W-1:0]        cfg_data = '0;

    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [OP_W-1:0]          operation = '0;
    logic [ID_W-1:0]          object_id = '0;
    logic [BOX_W-1:0]         box_id = '0;
    logic [GRP_W-1:0]         group_id = '0;
    logic signed [POS_W-1:0]  pos_x = '0;
    logic signed [POS_W-1:0]  pos_y = '0;
    logic [EXT_W-1:0]         box_width = '0;
    logic [EXT_W-1:0]         box_height = '0;
    logic [CNT_W-1:0]         start_count = '0;

    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [KIND_W-1:0]        kind;
    logic [ID_W-1:0]          other_id;
    logic                     last;

    aabb_collision_group_query_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .object_id   (object_id),
        .box_id      (box_id),
        .group_id    (group_id),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .box_width   (box_width),
        .box_height  (box_height),
        .start_count (start_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .other_id    (other_id),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // scene copy used for prediction
    obj_rec_t          obj_tab [N_OBJ];
    shape_rec_t        shape_tab [N_SHAPE];
    logic [ID_W-1:0]   members [NUM_GROUPS+1][LIST_CAP];
    int                member_cnt [NUM_GROUPS+1];
    logic [MASK_W-1:0] grp_mask [NUM_CFG];

    scene_item_t item_q [$];
    mask_write_t mask_q [$];
    report_t     due_reports [$];
    scene_item_t offered = '0;

    // what the stimulus side has written so far: only these get read back
    bit box_seen [N_SHAPE];
    bit obj_seen [N_OBJ];
    int live_boxes [$];
    int live_objs [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_arm = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int mismatch_count = 0;

    initial
    begin
        for (int g = 0; g <= NUM_GROUPS; g++)
            member_cnt[g] = 0;
        for (int r = 0; r < NUM_CFG; r++)
            grp_mask[r] = '0;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void box_bounds(input logic [BOX_W-1:0] b,
                                       input logic signed [POS_W-1:0] px,
                                       input logic signed [POS_W-1:0] py,
                                       output int x1, output int y1,
                                       output int x2, output int y2);
        shape_rec_t s;
        s  = shape_tab[b];
        x1 = int'($signed(s.cx)) + int'(px);
        y1 = int'($signed(s.cy)) + int'(py);
        x2 = x1 + int'(s.w);
        y2 = y1 + int'(s.h);
    endfunction

    function automatic void apply_item(input scene_item_t it);
        int ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
        int tally;
        bit overflow;
        obj_rec_t rec, peer;
        logic [ID_W-1:0] other;
        logic [MASK_W-1:0] sel;
        case (it.op)
            OP_WR_OBJ: obj_tab[it.oid] = '{box: it.bid, grp: it.gid, x: it.px, y: it.py};
            OP_WR_BOX: shape_tab[it.bid] = '{cx: it.px, cy: it.py, w: it.bw, h: it.bh};
            OP_APPEND:
                if (it.gid >= GRP_FIRST && it.gid <= GRP_LAST
                    && member_cnt[it.gid] < LIST_CAP)
                begin
                    members[it.gid][member_cnt[it.gid]] = it.oid;
                    member_cnt[it.gid]++;
                end
            OP_CLEAR:
                if (it.gid >= GRP_FIRST && it.gid <= GRP_LAST)
                    member_cnt[it.gid] = 0;
            OP_QUERY:
            begin
                rec = obj_tab[it.oid];
                box_bounds(rec.box, it.px, it.py, ax1, ay1, ax2, ay2);
                sel = grp_mask[rec.grp];
                tally = int'(it.start);
                overflow = 1'b0;
                for (int g = GRP_FIRST; g <= GRP_LAST; g++)
                begin
                    if (!overflow && sel[g])
                    begin
                        for (int m = 0; m < member_cnt[g]; m++)
                        begin
                            other = members[g][m];
                            if (!overflow && other != it.oid)
                            begin
                                peer = obj_tab[other];
                                box_bounds(peer.box, peer.x, peer.y, bx1, by1, bx2, by2);
                                if (bx1 <= ax2 && ax1 <= bx2 && by1 <= ay2 && ay1 <= by2)
                                begin
                                    // a hit with the list already full ends the query
                                    if (tally >= LIST_CAP)
                                    begin
                                        due_reports.push_back('{KIND_OVF, ID_W'(0), 1'b1});
                                        overflow = 1'b1;
                                    end
                                    else
                                    begin
                                        due_reports.push_back('{KIND_HIT, other, 1'b0});
                                        tally++;
                                    end
                                end
                            end
                        end
                    end
                end
                if (!overflow)
                    due_reports.push_back('{KIND_DONE, ID_W'(0), 1'b1});
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_item(input scene_item_t it);
        if (it.op == OP_WR_BOX && !box_seen[it.bid])
        begin
            box_seen[it.bid] = 1'b1;
            live_boxes.push_back(int'(it.bid));
        end
        if (it.op == OP_WR_OBJ && !obj_seen[it.oid])
        begin
            obj_seen[it.oid] = 1'b1;
            live_objs.push_back(int'(it.oid));
        end
        item_q.push_back(it);
    endfunction

    function automatic void directed(input logic [OP_W-1:0] op, input int oid, input int bid,
                                     input int gid, input int px, input int py,
                                     input int bw, input int bh, input int start);
        scene_item_t it;
        it = '{op, ID_W'(oid), BOX_W'(bid), GRP_W'(gid), POS_W'(px), POS_W'(py),
               EXT_W'(bw), EXT_W'(bh), CNT_W'(start)};
        queue_item(it);
    endfunction

    // mostly a crowded neighborhood, now and then anywhere
    function automatic logic signed [POS_W-1:0] pick_coord(input int spread);
        if ($urandom_range(9) == 0)
            return POS_W'($urandom);
        return POS_W'(int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic logic [EXT_W-1:0] pick_extent();
        if ($urandom_range(9) == 0)
            return EXT_W'($urandom);
        return EXT_W'($urandom_range(0, 60));
    endfunction

    function automatic logic [ID_W-1:0] pick_live_obj();
        return ID_W'(live_objs[$urandom_range(live_objs.size() - 1)]);
    endfunction

    function automatic scene_item_t random_item();
        scene_item_t it;
        int pick;
        int r;
        it.op    = OP_QUERY;
        it.oid   = ID_W'($urandom);
        it.bid   = BOX_W'($urandom);
        it.gid   = GRP_W'($urandom);
        it.px    = POS_W'($urandom);
        it.py    = POS_W'($urandom);
        it.bw    = EXT_W'($urandom);
        it.bh    = EXT_W'($urandom);
        it.start = CNT_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            it.op = OP_WR_BOX;
            it.px = pick_coord(20);
            it.py = pick_coord(20);
            it.bw = pick_extent();
            it.bh = pick_extent();
        end
        else if (pick < 26)
        begin
            it.op  = OP_WR_OBJ;
            it.bid = BOX_W'(live_boxes[$urandom_range(live_boxes.size() - 1)]);
            it.px  = pick_coord(120);
            it.py  = pick_coord(120);
        end
        else if (pick < 62)
        begin
            it.op  = OP_APPEND;
            it.oid = pick_live_obj();
            r = $urandom_range(19);
            if (r < 14)
                it.gid = GRP_W'($urandom_range(1, 3));
            else if (r < 19)
                it.gid = GRP_W'($urandom_range(4, 6));
            else
                it.gid = $urandom_range(1) ? '1 : '0;
        end
        else if (pick < 64)
            it.op = OP_CLEAR;
        else if (pick < 67)
            it.op = OP_W'($urandom_range(OP_QUERY + 1, OP_TOP_CODE));
        else
        begin
            it.oid = pick_live_obj();
            it.px  = pick_coord(120);
            it.py  = pick_coord(120);
            r = $urandom_range(9);
            if (r < 7)
                it.start = CNT_W'($urandom_range(0, 4));
            else if (r < 9)
                it.start = CNT_W'($urandom_range(25, LIST_CAP));
            else
                it.start = CNT_W'($urandom_range(LIST_CAP + 1, 63));
        end
        return it;
    endfunction

    // mask register writes
    always @(posedge clk or negedge rst_n)
    begin : mask_drive
        mask_write_t w;
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                grp_mask[cfg_index] = cfg_data;
            if (!cfg_valid || cfg_ready)
            begin
                if (mask_q.size() != 0)
                begin
                    w = mask_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.index;
                    cfg_data  <= w.data;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : item_drive
        scene_item_t nxt;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            offered     <= '0;
            operation   <= '0;
            object_id   <= '0;
            box_id      <= '0;
            group_id    <= '0;
            pos_x       <= '0;
            pos_y       <= '0;
            box_width   <= '0;
            box_height  <= '0;
            start_count <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                apply_item(offered);
            if (!in_valid || in_ready)
            begin
                if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = item_q.pop_front();
                    offered     <= nxt;
                    in_valid    <= 1'b1;
                    operation   <= nxt.op;
                    object_id   <= nxt.oid;
                    box_id      <= nxt.bid;
                    group_id    <= nxt.gid;
                    pos_x       <= nxt.px;
                    pos_y       <= nxt.py;
                    box_width   <= nxt.bw;
                    box_height  <= nxt.bh;
                    start_count <= nxt.start;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long output stall, started once on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_arm && !hold_taken)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_check
        report_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_reports.size() == 0)
                    flag_mismatch($sformatf("unexpected item: kind %0d id %0d last %0b",
                                            kind, other_id, last));
                else
                begin
                    want = due_reports.pop_front();
                    if (kind !== want.kind)
                        flag_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
                    if (other_id !== want.other)
                        flag_mismatch($sformatf("other_id %0d, expected %0d",
                                                other_id, want.other));
                    if (last !== want.last)
                        flag_mismatch($sformatf("last %0b, expected %0b", last, want.last));
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        scene_item_t it;
        logic [MASK_W-1:0] mask;
        int budget;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            for (int r = 0; r < NUM_CFG; r++)
            begin
                case (phase)
                    0: mask = FIRST_MASKS[r];
                    1: mask = MASK_W'($urandom);
                    2: mask = '1;
                    default: mask = '0;
                endcase
                mask_q.push_back('{CFG_W'(r), mask});
            end
            while (mask_q.size() != 0 || cfg_valid)
                @(negedge clk);

            case (phase)
                0:
                begin
                    send_idle_pct = 22;
                    recv_idle_pct = 86;
                end
                1:
                begin
                    send_idle_pct = 86;
                    recv_idle_pct = 22;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (phase == 0)
            begin
                directed(OP_WR_BOX, 0, 0, 0, 0, 0, 10, 10, 0);
                directed(OP_WR_BOX, 0, 15, 0, -32768, -32768, 32767, 32767, 0);
                directed(OP_WR_BOX, 0, 1, 0, 32767, 32767, 0, 0, 0);
                directed(OP_WR_OBJ, 0, 0, 1, 0, 0, 0, 0, 0);
                // corners touch: inclusive overlap
                directed(OP_WR_OBJ, 1, 0, 2, 10, 10, 0, 0, 0);
                // one unit clear of object 0
                directed(OP_WR_OBJ, 2, 0, 2, 11, 0, 0, 0, 0);
                directed(OP_WR_OBJ, 63, 15, 7, 32767, 32767, 0, 0, 0);
                directed(OP_WR_OBJ, 3, 1, 3, -32768, -32768, 0, 0, 0);
                directed(OP_WR_OBJ, 4, 0, 0, -32768, 32767, 0, 0, 0);
                directed(OP_APPEND, 0, 0, 1, 0, 0, 0, 0, 0);
                directed(OP_APPEND, 1, 0, 2, 0, 0, 0, 0, 0);
                directed(OP_APPEND, 2, 0, 2, 0, 0, 0, 0, 0);
                directed(OP_APPEND, 3, 0, 3, 0, 0, 0, 0, 0);
                directed(OP_APPEND, 63, 0, 6, 0, 0, 0, 0, 0);
                directed(OP_APPEND, 0, 0, 2, 0, 0, 0, 0, 0);
                directed(OP_APPEND, 4, 0, 0, 0, 0, 0, 0, 0);
                directed(OP_APPEND, 4, 0, 7, 0, 0, 0, 0, 0);
                directed(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
                directed(OP_QUERY, 63, 0, 0, 32767, 32767, 0, 0, LIST_CAP);
                directed(OP_QUERY, 1, 0, 0, -5, -5, 0, 0, 63);
                directed(OP_QUERY, 4, 0, 0, -32768, 32767, 0, 0, LIST_CAP - 1);
                directed(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
                directed(OP_CLEAR, 0, 0, 7, 0, 0, 0, 0, 0);
                directed(OP_W'(OP_QUERY + 1), 5, 3, 2, 1, 1, 1, 1, 1);
                directed(OP_TOP_CODE, 6, 4, 3, 2, 2, 2, 2, 2);
            end

            budget = (phase == 3) ? 60 : 130;
            while (budget > 0)
            begin
                it = random_item();
                queue_item(it);
                if (it.op <= OP_QUERY)
                    budget--;
            end

            if (phase == 2)
            begin
                while (item_q.size() > 100)
                    @(negedge clk);
                hold_arm = 1'b1;
            end

            while (item_q.size() != 0 || in_valid || due_reports.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
rtl/aabbq_pkg.sv
rtl/aabbq_ram.sv
rtl/aabbq_members.sv
rtl/aabb_collision_group_query_top.sv
tb/tb.sv
